// ===== rtl/tab_expanding_output_fifo_macros.svh =====
// Assertion macros for the tab-expanding output FIFO.
// Included by the top level; the assertions use its clk and rst signals.
`ifndef TAB_EXPANDING_OUTPUT_FIFO_MACROS_SVH
`define TAB_EXPANDING_OUTPUT_FIFO_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define TEFO_ASSERT_NOW(label, pre, con) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
    else $error("tab_expanding_output_fifo: check failed");
// Consequent must hold in the cycle after the antecedent.
`define TEFO_ASSERT_NEXT(label, pre, con) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
    else $error("tab_expanding_output_fifo: check failed");
`else
`define TEFO_ASSERT_NOW(label, pre, con)
`define TEFO_ASSERT_NEXT(label, pre, con)
`endif
`endif

// ===== rtl/tefo_pkg.sv =====
// Shared types and constants for the tab-expanding output FIFO.
// Used by tefo_ctrl, tefo_dp and tab_expanding_output_fifo; no dependencies.
package tefo_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int COL_W = 8;
  localparam int CNT_W = 4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PUSH,
    ST_RESULT
  } tefo_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic push;
    logic pop;
  } tefo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic tab_more;
  } tefo_stat_t;

endpackage

// ===== rtl/tefo_ctrl.sv =====
// Sequencer for the tab-expanding output FIFO.
// Depends on tefo_pkg for the state enum and the command/status structs.
module tefo_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tefo_pkg::tefo_stat_t stat,
  output tefo_pkg::tefo_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import tefo_pkg::*;

  tefo_state_t state;
  tefo_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stat.is_read) begin
          state_next = ST_POP;
        end else begin
          cmd.push = 1'b1;
          if (!stat.tab_more) begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tefo_dp.sv =====
// Datapath of the tab-expanding output FIFO: ring memory, pointers, column.
// Depends on tefo_pkg for constants and the command/status structs.
module tefo_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tefo_pkg::tefo_cmd_t            cmd,
  output tefo_pkg::tefo_stat_t           stat,
  input  logic                           kind,
  input  logic [7:0]                     char_in,
  input  logic                           end_of_write,
  output logic [7:0]                     read_byte,
  output logic                           read_valid,
  output logic [tefo_pkg::CNT_W-1:0]     pushed_count,
  output logic                           overflow,
  output logic [tefo_pkg::COL_W-1:0]     column_now,
  output logic                           write_done
);
  import tefo_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic [CNT_W-1:0] cnt;
  logic             ovf;
  logic             is_read;
  logic [7:0]       ch;
  logic             eow;
  logic [7:0]       rbyte;
  logic             rvalid;
  logic [7:0]       push_byte;
  logic             full;
  logic             empty;
  logic             is_tab;

  assign wr_ptr_inc = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign full       = (wr_ptr_inc == rd_ptr);
  assign empty      = (wr_ptr == rd_ptr);
  assign is_tab     = (ch == CH_TAB);

  // Column update and byte for one push step.
  always_comb begin
    push_byte = ch;
    if (is_tab) begin
      push_byte   = CH_SPACE;
      column_next = column + 1'b1;
    end else if (ch == CH_NL || ch == CH_CR) begin
      column_next = '0;
    end else if (ch == CH_BS) begin
      column_next = (column != '0) ? column - 1'b1 : '0;
    end else begin
      column_next = column + 1'b1;
    end
  end

  assign stat.is_read  = is_read;
  assign stat.tab_more = is_tab && (column_next[2:0] != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      column <= '0;
    end else begin
      if (cmd.push) begin
        column <= column_next;
        if (!full) begin
          wr_ptr <= wr_ptr_inc;
        end
      end
      if (cmd.pop && !empty) begin
        rd_ptr <= rd_ptr_inc;
      end
    end
  end

  // Per-item result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read <= kind;
      ch      <= char_in;
      eow     <= end_of_write && (kind == KIND_WRITE);
      cnt     <= '0;
      ovf     <= 1'b0;
      rbyte   <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.pop && !empty) begin
        rbyte  <= mem[rd_ptr];
        rvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[wr_ptr] <= push_byte;
    end
  end

  assign read_byte    = rbyte;
  assign read_valid   = rvalid;
  assign pushed_count = cnt;
  assign overflow     = ovf;
  assign column_now   = column;
  assign write_done   = eow;

endmodule

// ===== rtl/tab_expanding_output_fifo.sv =====
// Top level of the tab-expanding terminal output FIFO.
// Uses tefo_pkg, tefo_ctrl, tefo_dp and tab_expanding_output_fifo_macros.svh.
//
//   Channel   Handshake          Payload
//   -------   ----------------   ---------------------------------------------
//   command   start / busy       kind, char_in, end_of_write
//   result    done (one cycle)   read_byte, read_valid, pushed_count,
//                                overflow, column_now, write_done
//
// A transfer on the command channel happens when start is high and busy is low.
// A read then passes ST_PUSH, ST_POP and ST_RESULT; a write pushes one byte in
// ST_PUSH, and a tab one byte per space, pushed or dropped (up to 8), as the
// single memory write port stores one byte per cycle.
// The next command is taken in the cycle after done. Reset (rst, synchronous)
// empties the FIFO and zeroes the column; memory contents are not cleared.
// The receiver cannot stall: each result is valid only while done is high.
`include "tab_expanding_output_fifo_macros.svh"

module tab_expanding_output_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [7:0]                     char_in,
  input  logic                           end_of_write,
  output logic                           done,
  output logic [7:0]                     read_byte,
  output logic                           read_valid,
  output logic [tefo_pkg::CNT_W-1:0]     pushed_count,
  output logic                           overflow,
  output logic [tefo_pkg::COL_W-1:0]     column_now,
  output logic                           write_done
);
  import tefo_pkg::*;

  // Commands flow from the sequencer to the datapath; status flows back.
  tefo_cmd_t  cmd;
  tefo_stat_t stat;

  // The sequencer walks each item through load, push or pop, and result.
  tefo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath owns the ring memory, both pointers and the column counter.
  tefo_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .char_in      (char_in),
    .end_of_write (end_of_write),
    .read_byte    (read_byte),
    .read_valid   (read_valid),
    .pushed_count (pushed_count),
    .overflow     (overflow),
    .column_now   (column_now),
    .write_done   (write_done)
  );

  // A result strobe lasts exactly one cycle.
  `TEFO_ASSERT_NEXT(a_done_single, done, !done)
  // A new transfer always makes the block busy in the next cycle.
  `TEFO_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // A read result never reports pushed bytes, an overflow or a write end.
  `TEFO_ASSERT_NOW(a_read_clean, done && read_valid,
                   pushed_count == '0 && !overflow && !write_done)
  // A write pushes at most one tab stop worth of bytes.
  `TEFO_ASSERT_NOW(a_push_bound, done, pushed_count <= CNT_W'(8))

endmodule
